@@ hw/rtl/tcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle cotangent unit package
// Shared constants and the result type passed from each angle pipe to the top.
// ----------------------------------------------------------------------------
package tcu_pkg;

   localparam int SIDE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int PORT_W         = 32;
   localparam int ALIGN_BITS     = 31;
   localparam int COS_FRAC       = 30;
   localparam int OUT_W          = 32;

   localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic             valid;
      logic             deg;
      logic [OUT_W-1:0] cot;
   } tcu_res_type;

endpackage

@@ hw/rtl/tcu_cot_path.sv @@
// ----------------------------------------------------------------------------
// Cotangent pipe for one angle
// Law of cosines, bit-serial cosine divide, square root and final divide,
// one step per register stage.
// ----------------------------------------------------------------------------
module tcu_cot_path import tcu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ALIGN_BITS-1:0] x_side,
   input  logic [ALIGN_BITS-1:0] y_side,
   input  logic [ALIGN_BITS-1:0] z_side,
   output tcu_res_type           result
);

   localparam int SQ_W  = 2 * ALIGN_BITS;
   localparam int NUM_W = SQ_W + 1;
   localparam int QW    = COS_FRAC + FRAC_BITS;
   localparam int N_W   = 2 * COS_FRAC + 1;
   localparam int RES_W = N_W + 1;
   localparam int S_W   = COS_FRAC + 1;
   localparam int SQ_STEPS = COS_FRAC + 1;

   // Stage P1: products.
   logic            p1_valid_ff;
   logic [SQ_W-1:0] xsq_ff, ysq_ff, zsq_ff, yz_ff;
   logic            p1_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else p1_valid_ff <= in_valid;
      xsq_ff     <= x_side * x_side;
      ysq_ff     <= y_side * y_side;
      zsq_ff     <= z_side * z_side;
      yz_ff      <= y_side * z_side;
      p1_zero_ff <= (y_side == '0) || (z_side == '0);
   end

   // Stage P2: sum of the adjacent squares.
   logic             p2_valid_ff, p2_zero_ff;
   logic [NUM_W-1:0] p2_sum_ff, p2_xsq_ff, p2_den_ff;

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else p2_valid_ff <= p1_valid_ff;
      p2_sum_ff  <= {1'b0, ysq_ff} + {1'b0, zsq_ff};
      p2_xsq_ff  <= {1'b0, xsq_ff};
      p2_den_ff  <= {yz_ff, 1'b0};
      p2_zero_ff <= p1_zero_ff;
   end

   // Stage P3: sign and magnitude of the numerator.
   logic             p3_valid_ff, p3_zero_ff, p3_neg_ff;
   logic [NUM_W-1:0] p3_mag_ff, p3_den_ff;

   always_ff @(posedge clock) begin
      if (reset) p3_valid_ff <= 1'b0;
      else p3_valid_ff <= p2_valid_ff;
      p3_neg_ff  <= p2_sum_ff < p2_xsq_ff;
      p3_mag_ff  <= (p2_sum_ff < p2_xsq_ff) ? (p2_xsq_ff - p2_sum_ff)
                                            : (p2_sum_ff - p2_xsq_ff);
      p3_den_ff  <= p2_den_ff;
      p3_zero_ff <= p2_zero_ff;
   end

   // Cosine divide: one quotient bit per stage.
   logic                d_valid_ff [0:COS_FRAC];
   logic                d_deg_ff   [0:COS_FRAC];
   logic                d_neg_ff   [0:COS_FRAC];
   logic [NUM_W-1:0]    d_r_ff     [0:COS_FRAC];
   logic [NUM_W-1:0]    d_den_ff   [0:COS_FRAC];
   logic [COS_FRAC-1:0] d_q_ff     [0:COS_FRAC];

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff[0] <= 1'b0;
      else d_valid_ff[0] <= p3_valid_ff;
      d_deg_ff[0] <= p3_zero_ff || (p3_mag_ff >= p3_den_ff);
      d_neg_ff[0] <= p3_neg_ff;
      d_r_ff[0]   <= p3_mag_ff;
      d_den_ff[0] <= p3_den_ff;
      d_q_ff[0]   <= '0;
   end

   for (genvar g = 0; g < COS_FRAC; g++) begin : g_cdiv
      logic [NUM_W:0]   shifted;
      logic             take;
      logic [NUM_W-1:0] r_in;

      always_comb begin
         shifted = {d_r_ff[g], 1'b0};
         take    = shifted >= {1'b0, d_den_ff[g]};
         r_in    = take ? NUM_W'(shifted - {1'b0, d_den_ff[g]}) : shifted[NUM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) d_valid_ff[g+1] <= 1'b0;
         else d_valid_ff[g+1] <= d_valid_ff[g];
         d_deg_ff[g+1] <= d_deg_ff[g];
         d_neg_ff[g+1] <= d_neg_ff[g];
         d_r_ff[g+1]   <= r_in;
         d_den_ff[g+1] <= d_den_ff[g];
         d_q_ff[g+1]   <= {d_q_ff[g][COS_FRAC-2:0], take};
      end
   end

   // Square of the cosine.
   logic                  qs_valid_ff, qs_deg_ff, qs_neg_ff;
   logic [COS_FRAC-1:0]   qs_q_ff;
   logic [2*COS_FRAC-1:0] qs_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) qs_valid_ff <= 1'b0;
      else qs_valid_ff <= d_valid_ff[COS_FRAC];
      qs_deg_ff <= d_deg_ff[COS_FRAC];
      qs_neg_ff <= d_neg_ff[COS_FRAC];
      qs_q_ff   <= d_q_ff[COS_FRAC];
      qs_sq_ff  <= d_q_ff[COS_FRAC] * d_q_ff[COS_FRAC];
   end

   // Square root of 1 - cos^2, one result bit per stage.
   logic                s_valid_ff [0:SQ_STEPS];
   logic                s_deg_ff   [0:SQ_STEPS];
   logic                s_neg_ff   [0:SQ_STEPS];
   logic [COS_FRAC-1:0] s_q_ff     [0:SQ_STEPS];
   logic [N_W-1:0]      s_n_ff     [0:SQ_STEPS];
   logic [RES_W-1:0]    s_res_ff   [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) s_valid_ff[0] <= 1'b0;
      else s_valid_ff[0] <= qs_valid_ff;
      s_deg_ff[0] <= qs_deg_ff;
      s_neg_ff[0] <= qs_neg_ff;
      s_q_ff[0]   <= qs_q_ff;
      s_n_ff[0]   <= (N_W'(1) << (2 * COS_FRAC)) - {1'b0, qs_sq_ff};
      s_res_ff[0] <= '0;
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * COS_FRAC - 2 * k);
      logic [RES_W-1:0] trial;
      logic             take;
      logic [N_W-1:0]   n_in;
      logic [RES_W-1:0] res_in;

      always_comb begin
         trial  = s_res_ff[k] + BIT;
         take   = {1'b0, s_n_ff[k]} >= trial;
         n_in   = take ? N_W'({1'b0, s_n_ff[k]} - trial) : s_n_ff[k];
         res_in = take ? ((s_res_ff[k] >> 1) + BIT) : (s_res_ff[k] >> 1);
      end

      always_ff @(posedge clock) begin
         if (reset) s_valid_ff[k+1] <= 1'b0;
         else s_valid_ff[k+1] <= s_valid_ff[k];
         s_deg_ff[k+1] <= s_deg_ff[k];
         s_neg_ff[k+1] <= s_neg_ff[k];
         s_q_ff[k+1]   <= s_q_ff[k];
         s_n_ff[k+1]   <= n_in;
         s_res_ff[k+1] <= res_in;
      end
   end

   // Final divide of the shifted cosine by the sine.
   logic           f_valid_ff [0:QW];
   logic           f_deg_ff   [0:QW];
   logic           f_neg_ff   [0:QW];
   logic [S_W-1:0] f_s_ff     [0:QW];
   logic [S_W-1:0] f_r_ff     [0:QW];
   logic [QW-1:0]  f_dvd_ff   [0:QW];
   logic [QW-1:0]  f_quo_ff   [0:QW];

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff[0] <= 1'b0;
      else f_valid_ff[0] <= s_valid_ff[SQ_STEPS];
      f_deg_ff[0] <= s_deg_ff[SQ_STEPS] || (s_res_ff[SQ_STEPS][S_W-1:0] == '0);
      f_neg_ff[0] <= s_neg_ff[SQ_STEPS];
      f_s_ff[0]   <= s_res_ff[SQ_STEPS][S_W-1:0];
      f_r_ff[0]   <= '0;
      f_dvd_ff[0] <= {s_q_ff[SQ_STEPS], {FRAC_BITS{1'b0}}};
      f_quo_ff[0] <= '0;
   end

   for (genvar j = 0; j < QW; j++) begin : g_fdiv
      logic [S_W:0]   shifted;
      logic           take;
      logic [S_W-1:0] r_in;

      always_comb begin
         shifted = {f_r_ff[j], f_dvd_ff[j][QW-1]};
         take    = shifted >= {1'b0, f_s_ff[j]};
         r_in    = take ? S_W'(shifted - {1'b0, f_s_ff[j]}) : shifted[S_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) f_valid_ff[j+1] <= 1'b0;
         else f_valid_ff[j+1] <= f_valid_ff[j];
         f_deg_ff[j+1] <= f_deg_ff[j];
         f_neg_ff[j+1] <= f_neg_ff[j];
         f_s_ff[j+1]   <= f_s_ff[j];
         f_r_ff[j+1]   <= r_in;
         f_dvd_ff[j+1] <= {f_dvd_ff[j][QW-2:0], 1'b0};
         f_quo_ff[j+1] <= {f_quo_ff[j][QW-2:0], take};
      end
   end

   // Sign, saturation and output register.
   logic [OUT_W-1:0] cot_in;
   logic [QW-1:0]    quo;

   always_comb begin
      quo = f_quo_ff[QW];
      if (f_deg_ff[QW]) begin
         cot_in = f_neg_ff[QW] ? NEG_LIMIT : POS_LIMIT;
      end else if (!f_neg_ff[QW]) begin
         cot_in = (quo > QW'(POS_LIMIT)) ? POS_LIMIT : quo[OUT_W-1:0];
      end else begin
         cot_in = (quo > QW'(NEG_LIMIT)) ? NEG_LIMIT : (OUT_W'(0) - quo[OUT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) result.valid <= 1'b0;
      else result.valid <= f_valid_ff[QW];
      result.deg <= f_deg_ff[QW];
      result.cot <= cot_in;
   end

endmodule

@@ hw/rtl/triangle_cotangent_unit_top.sv @@
// ----------------------------------------------------------------------------
// Triangle cotangent unit, top level
// Cotangents of the angles opposite sides a and c from three side lengths.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is never raised because every stage
// advances each cycle and the result side cannot stall. Reset is synchronous:
// it clears all valid bits, so no result strobes until items arrive after
// reset is released.
module triangle_cotangent_unit_top import tcu_pkg::*; #(
   parameter int SIDE_WIDTH = SIDE_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [PORT_W-1:0]       req_side_a,
   input  logic [PORT_W-1:0]       req_side_b,
   input  logic [PORT_W-1:0]       req_side_c,
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_cot_opposite_a,
   output logic signed [OUT_W-1:0] rsp_cot_opposite_c,
   output logic                    rsp_degenerate
);

   // Only the low SIDE_WIDTH bits of each side take part.
   localparam int IN_W  = (SIDE_WIDTH < PORT_W) ? SIDE_WIDTH : PORT_W;
   localparam int LEN_W = $clog2(PORT_W + 1);

   assign busy = 1'b0;

   // Input register stage.
   logic              in_valid_ff;
   logic [PORT_W-1:0] a_ff, b_ff, c_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= start;
      a_ff <= PORT_W'(req_side_a[IN_W-1:0]);
      b_ff <= PORT_W'(req_side_b[IN_W-1:0]);
      c_ff <= PORT_W'(req_side_c[IN_W-1:0]);
   end

   // Alignment: when the largest side needs more than ALIGN_BITS bits, all
   // three sides are shifted right together until it fits. The cosines are
   // scale free, so this only drops low-order precision.
   logic [PORT_W-1:0] side_max;
   logic [LEN_W-1:0]  max_len;
   logic [LEN_W-1:0]  shift_amt;

   always_comb begin
      side_max = a_ff;
      if (b_ff > side_max) side_max = b_ff;
      if (c_ff > side_max) side_max = c_ff;
      max_len = '0;
      for (int i = 0; i < PORT_W; i++) begin
         if (side_max[i]) max_len = LEN_W'(i + 1);
      end
      shift_amt = (max_len > LEN_W'(ALIGN_BITS)) ? (max_len - LEN_W'(ALIGN_BITS)) : '0;
   end

   logic                  al_valid_ff;
   logic [ALIGN_BITS-1:0] al_a_ff, al_b_ff, al_c_ff;

   always_ff @(posedge clock) begin
      if (reset) al_valid_ff <= 1'b0;
      else al_valid_ff <= in_valid_ff;
      al_a_ff <= ALIGN_BITS'(a_ff >> shift_amt);
      al_b_ff <= ALIGN_BITS'(b_ff >> shift_amt);
      al_c_ff <= ALIGN_BITS'(c_ff >> shift_amt);
   end

   // Angle opposite a has adjacent sides b and c; angle opposite c has
   // adjacent sides b and a. Both pipes have the same depth, so their
   // results arrive in the same cycle.
   tcu_res_type res_a, res_c;

   tcu_cot_path #(.FRAC_BITS(FRAC_BITS)) u_path_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (al_valid_ff),
      .x_side   (al_a_ff),
      .y_side   (al_b_ff),
      .z_side   (al_c_ff),
      .result   (res_a)
   );

   tcu_cot_path #(.FRAC_BITS(FRAC_BITS)) u_path_c (
      .clock    (clock),
      .reset    (reset),
      .in_valid (al_valid_ff),
      .x_side   (al_c_ff),
      .y_side   (al_b_ff),
      .z_side   (al_a_ff),
      .result   (res_c)
   );

   assign rsp_strobe         = res_a.valid & res_c.valid;
   assign rsp_cot_opposite_a = res_a.cot;
   assign rsp_cot_opposite_c = res_c.cot;
   assign rsp_degenerate     = res_a.deg | res_c.deg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle cotangent unit testbench
// Streams side-length triples through the unit with random gaps on the
// request side. Each taken item is run through an in-bench cotangent
// predictor, and each strobed result is checked in order against it.
// ----------------------------------------------------------------------------

// Holds the expected cotangent pairs for all items still in the pipeline.
class cot_scoreboard;
   typedef struct {
      logic [31:0] cot_a;
      logic [31:0] cot_c;
      logic        deg;
   } cot_result_type;

   cot_result_type pending_q[$];
   int unsigned error_count;

   function logic [31:0] saturate(bit neg, logic [63:0] mag);
      if (!neg)
         return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      if (mag > 64'h8000_0000)
         mag = 64'h8000_0000;
      return 32'h0 - mag[31:0];
   endfunction

   function logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] probe;
      root = 0;
      probe = 64'h1 << 62;
      while (probe > n)
         probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Cotangent of the angle opposite x, with adjacent sides y and z.
   function logic [31:0] angle_cot(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                   inout bit deg);
      logic [63:0] sum, xsq, mag, den, quo, rem, sin_sq, sin_v;
      bit neg;
      sum = y * y + z * z;
      xsq = x * x;
      neg = sum < xsq;
      mag = neg ? xsq - sum : sum - xsq;
      den = 2 * y * z;
      if (y == 0 || z == 0 || mag >= den) begin
         deg = 1;
         return saturate(neg, '1);
      end
      quo = 0;
      rem = mag;
      for (int i = 0; i < 30; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      sin_sq = (64'h1 << 60) - quo * quo;
      sin_v = floor_sqrt(sin_sq);
      if (sin_v == 0) begin
         deg = 1;
         return saturate(neg, '1);
      end
      return saturate(neg, (quo << 16) / sin_v);
   endfunction

   function void note_item(logic [31:0] side_a, logic [31:0] side_b, logic [31:0] side_c);
      logic [63:0] a, b, c, big;
      int shift;
      bit deg;
      cot_result_type res;
      a = {32'h0, side_a};
      b = {32'h0, side_b};
      c = {32'h0, side_c};
      big = a;
      if (b > big) big = b;
      if (c > big) big = c;
      // Only a full 32-bit side exceeds the 31-bit alignment width.
      shift = big[31] ? 1 : 0;
      a = a >> shift;
      b = b >> shift;
      c = c >> shift;
      deg = 0;
      res.cot_a = angle_cot(a, b, c, deg);
      res.cot_c = angle_cot(c, b, a, deg);
      res.deg = deg;
      pending_q.push_back(res);
   endfunction

   function void check_result(logic [31:0] cot_a, logic [31:0] cot_c, logic deg);
      cot_result_type exp_res;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result cot_a=%h cot_c=%h deg=%b", $time, cot_a, cot_c, deg);
         error_count++;
         return;
      end
      exp_res = pending_q.pop_front();
      if (cot_a !== exp_res.cot_a) begin
         $display("%0t: cot_opposite_a expected %h actual %h", $time, exp_res.cot_a, cot_a);
         error_count++;
      end
      if (cot_c !== exp_res.cot_c) begin
         $display("%0t: cot_opposite_c expected %h actual %h", $time, exp_res.cot_c, cot_c);
         error_count++;
      end
      if (deg !== exp_res.deg) begin
         $display("%0t: degenerate expected %b actual %b", $time, exp_res.deg, deg);
         error_count++;
      end
   endfunction
endclass

module tb;

   // The drain is longer than the pipeline is deep, which leaves some margin.
   localparam int DRAIN_CYCLES = 160;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [31:0] ONE = 32'h0001_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_side_a;
   logic [31:0] req_side_b;
   logic [31:0] req_side_c;
   logic        rsp_strobe;
   logic signed [31:0] rsp_cot_opposite_a;
   logic signed [31:0] rsp_cot_opposite_c;
   logic        rsp_degenerate;

   cot_scoreboard cot_sb;
   int unsigned cycle_count;

   triangle_cotangent_unit_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_side_a         (req_side_a),
      .req_side_b         (req_side_b),
      .req_side_c         (req_side_c),
      .rsp_strobe         (rsp_strobe),
      .rsp_cot_opposite_a (rsp_cot_opposite_a),
      .rsp_cot_opposite_c (rsp_cot_opposite_c),
      .rsp_degenerate     (rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Results cannot be held off, so every strobed cycle is checked. The
   // outputs are sampled at the edge before the unit's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         cot_sb.check_result(rsp_cot_opposite_a, rsp_cot_opposite_c, rsp_degenerate);
   end

   // A hung pipeline must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Presents one item and holds it until a clock edge takes it. The start
   // line is left high so that a following item can go back to back.
   task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      req_side_a <= a;
      req_side_b <= b;
      req_side_c <= c;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      cot_sb.note_item(a, b, c);
   endtask

   task automatic idle(int unsigned cycles);
      if (cycles == 0)
         return;
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly no gap or a short one, now and then a long stretch.
   function automatic int unsigned gap_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [31:0] rand_side(int unsigned width);
      logic [31:0] value;
      value = $urandom;
      return (width >= 32) ? value : value & ((32'h1 << width) - 1);
   endfunction

   // Picks a side that closes a valid triangle with b and c, sometimes right at
   // a flat limit where the angle opposite it approaches 180 or 0 degrees.
   function automatic logic [31:0] closing_side(logic [31:0] b, logic [31:0] c);
      logic [63:0] lo, hi, span, pick;
      lo = (b > c) ? {32'h0, b - c} : {32'h0, c - b};
      hi = {32'h0, b} + {32'h0, c};
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      case ($urandom_range(0, 9))
         0: return hi[31:0];
         1: return lo[31:0];
         default: begin
            span = hi - lo + 1;
            pick = lo + ({$urandom, $urandom} % span);
            return pick[31:0];
         end
      endcase
   endfunction

   task automatic drain_pipeline();
      while (cot_sb.pending_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] a, b, c;
      int unsigned width;

      cot_sb = new();
      start = 1'b0;
      req_side_a = '0;
      req_side_b = '0;
      req_side_c = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero sides, full-scale sides that need alignment,
      // flat and impossible triangles, and a few ordinary shapes.
      send_item(0, 0, 0);
      send_item(0, ONE, ONE);
      send_item(ONE, 0, ONE);
      send_item(ONE, ONE, 0);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      idle(3);
      send_item(ONE, ONE, ONE);
      send_item(3 * ONE, 4 * ONE, 5 * ONE);
      send_item(5 * ONE, 4 * ONE, 3 * ONE);
      send_item(ONE, 2 * ONE, 3 * ONE);
      send_item(3 * ONE, 2 * ONE, ONE);
      send_item(ONE, ONE, 5 * ONE);
      send_item(5 * ONE, ONE, ONE);
      idle(7);
      send_item(ONE, ONE, 2 * ONE - 1);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
      send_item(32'h7FFF_FFFF, 32'h4000_0000, 32'h4000_0000);
      send_item(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      idle(1);
      send_item(2, 3, 4);

      // Hold the request side off until the pipeline has fully emptied.
      idle(1);
      drain_pipeline();

      // Random part: mostly genuine triangles at many scales, some wholly
      // random triples, with back-to-back bursts every so often.
      for (int n = 0; n < 700; n++) begin
         width = $urandom_range(1, 32);
         b = rand_side(width);
         c = rand_side(width);
         if ($urandom_range(0, 4) == 0) begin
            a = $urandom;
            b = $urandom;
            c = $urandom;
         end else begin
            a = closing_side(b, c);
            if ($urandom_range(0, 1)) begin
               {a, c} = {c, a};
            end
         end
         send_item(a, b, c);
         if ((n % 100) >= 70 || n == 699)
            idle((n == 699) ? 1 : gap_len());
         if (n == 350) begin
            idle(1);
            drain_pipeline();
         end
      end

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cot_sb.error_count == 0 && cot_sb.pending_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
